### design/snm_pkg.sv
// Shared constants for the skew-normal moments pipeline.
package snm_pkg;

   // Default fraction bits of the interface Q formats
   localparam int FRAC_BITS_DEF = 16;

   // Field widths
   localparam int LOC_W   = 32;
   localparam int SCALE_W = 31;
   localparam int SHAPE_W = 32;
   localparam int MEAN_W  = 32;
   localparam int VAR_W   = 46;
   localparam int SD_W    = 31;
   localparam int SKEW_W  = 18;
   localparam int KURT_W  = 17;

   // Q0.30 internal format
   localparam int Q_SH = 30;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Constants in Q.30, rounded to nearest
   localparam logic [29:0] K_SQRT_2_PI = 30'd856722024;
   localparam logic [29:0] K_SKEW      = 30'd460853935;
   localparam logic [29:0] K_KURT      = 30'd304067909;

   // Digit cells per divider and per square root chain
   localparam int DIV_STEPS  = 32;
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W     = 64;

endpackage

### design/snm_div_cell.sv
// One restoring division cell: shifts in one dividend bit and forms one quotient bit.
module snm_div_cell #(
   parameter int REM_W  = 64,
   parameter int Q_W    = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [REM_W-1:0]  rem_i,
   input  logic [Q_W-1:0]    quo_i,
   input  logic [REM_W-1:0]  den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [REM_W-1:0]  rem_o,
   output logic [Q_W-1:0]    quo_o,
   output logic [REM_W-1:0]  den_o,
   output logic [SIDE_W-1:0] side_o
);

   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh;
   logic [Q_W-1:0]    quo_ff, quo_in, quo_sh;
   logic [REM_W-1:0]  den_ff;
   logic [SIDE_W-1:0] side_ff;

   // Shift remainder and quotient together, subtract where the divisor fits
   always_comb begin
      rem_sh = {rem_i[REM_W-2:0], quo_i[Q_W-1]};
      quo_sh = {quo_i[Q_W-2:0], 1'b0};
      if (rem_sh >= den_i) begin
         rem_in = rem_sh - den_i;
         quo_in = quo_sh | Q_W'(1);
      end else begin
         rem_in = rem_sh;
         quo_in = quo_sh;
      end
   end

   // Advance to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_i;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;
   assign den_o  = den_ff;
   assign side_o = side_ff;

endmodule

### design/snm_sqrt_cell.sv
// One digit cell of the integer square root (floor), for a fixed trial bit.
module snm_sqrt_cell #(
   parameter int W       = 64,
   parameter int BIT_POS = 62,
   parameter int SIDE_W  = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [W-1:0]      rad_i,
   input  logic [W-1:0]      root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [W-1:0]      rad_o,
   output logic [W-1:0]      root_o,
   output logic [SIDE_W-1:0] side_o
);

   localparam logic [W-1:0] BIT_VAL = W'(1) << BIT_POS;

   logic [W-1:0]      rad_ff, rad_in;
   logic [W-1:0]      root_ff, root_in;
   logic [W-1:0]      trial;
   logic [SIDE_W-1:0] side_ff;

   // Try the bit, keep it where the radicand allows
   always_comb begin
      trial = root_i + BIT_VAL;
      if (rad_i >= trial) begin
         rad_in  = rad_i - trial;
         root_in = (root_i >> 1) + BIT_VAL;
      end else begin
         rad_in  = rad_i;
         root_in = root_i >> 1;
      end
   end

   // Advance to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign rad_o  = rad_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;

endmodule

### design/skew_normal_moments_unit.sv
// Top level: pipelined moments of a skew-normal distribution in fixed point.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid/ready, location, scale, shape | in
//  result  | rsp_valid/ready, five moment fields     | out
//
// One transaction enters per cycle while the pipe is not stalled; its result is valid after
// 137 register stages: four chains of 32 digit cells (shape divider, delta root,
// y root, skewness and kurtosis dividers side by side) plus nine single stages.
// Reset clears the stage valid bits and the skid buffer; payload is not reset.
// When a result is held by the consumer the whole pipe holds; one more request
// is still taken into a skid buffer, so req_ready is a register.
module skew_normal_moments_unit #(
   parameter int FRAC_BITS = snm_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [snm_pkg::LOC_W-1:0]   req_location,
   input  logic [snm_pkg::SCALE_W-1:0]        req_scale,
   input  logic signed [snm_pkg::SHAPE_W-1:0] req_shape,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [snm_pkg::MEAN_W-1:0]  rsp_mean_out,
   output logic [snm_pkg::VAR_W-1:0]          rsp_variance_out,
   output logic [snm_pkg::SD_W-1:0]           rsp_std_dev_out,
   output logic signed [snm_pkg::SKEW_W-1:0]  rsp_skewness_out,
   output logic [snm_pkg::KURT_W-1:0]         rsp_excess_kurtosis_out
);

   import snm_pkg::*;

   localparam int PIPE_LAT = 9 + 4 * 32;
   localparam logic [63:0] ONE_2F   = 64'(1) << (2 * FRAC_BITS);
   localparam logic [63:0] LIM_RAW  = 64'(1) << FRAC_BITS;
   localparam logic [63:0] MOM_LIM  = (LIM_RAW > 64'h1FFFF) ? 64'h1FFFF : LIM_RAW;
   localparam logic [92:0] VAR_MAX  = 93'((64'(1) << VAR_W) - 64'(1));
   localparam int VAR_SH = Q_SH + FRAC_BITS;
   localparam int MOM_SH = 2 * Q_SH - FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] loc;
      logic [30:0]        sc;
      logic               neg;
   } front_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic [29:0]        m;
      logic [29:0]        m2;
      logic [30:0]        y;
      logic [30:0]        sc;
      logic               neg;
   } mid_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic [45:0]        var_v;
      logic [30:0]        sd;
   } back_type;

   localparam int FRONT_W = $bits(front_type);
   localparam int MID_W   = $bits(mid_type);
   localparam int BACK_W  = $bits(back_type);

   // Flow control
   logic en;
   logic in_take;
   logic src_valid;
   logic [PIPE_LAT-1:0] vld_ff;
   logic skid_valid_ff;
   logic signed [31:0] skid_loc_ff, src_loc;
   logic [30:0] skid_sc_ff, src_sc;
   logic signed [31:0] skid_shp_ff, src_shp;

   assign en        = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign in_take   = req_valid && req_ready;
   assign src_valid = skid_valid_ff || in_take;
   assign src_loc   = skid_valid_ff ? skid_loc_ff : req_location;
   assign src_sc    = skid_valid_ff ? skid_sc_ff : req_scale;
   assign src_shp   = skid_valid_ff ? skid_shp_ff : req_shape;

   // Hold one transaction while the pipe is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (in_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && in_take) begin
         skid_loc_ff <= req_location;
         skid_sc_ff  <= req_scale;
         skid_shp_ff <= req_shape;
      end
   end

   // Advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], src_valid};
      end
   end

   // Stage 0: split shape into sign and magnitude
   front_type   s0_side_ff;
   logic [31:0] s0_amag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff.loc <= src_loc;
         s0_side_ff.sc  <= src_sc;
         s0_side_ff.neg <= src_shp[31];
         s0_amag_ff     <= src_shp[31] ? 32'(-src_shp) : 32'(src_shp);
      end
   end

   // Stage 1: square the shape magnitude
   front_type   s1_side_ff;
   logic [63:0] s1_a2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s0_side_ff;
         s1_a2_ff   <= 64'(s0_amag_ff) * 64'(s0_amag_ff);
      end
   end

   // Divider chain: delta^2 = a^2 / (1 + a^2) in Q0.32
   logic [63:0]        d1_rem  [0:DIV_STEPS];
   logic [31:0]        d1_quo  [0:DIV_STEPS];
   logic [63:0]        d1_den  [0:DIV_STEPS];
   logic [FRONT_W-1:0] d1_side [0:DIV_STEPS];

   assign d1_rem[0]  = s1_a2_ff;
   assign d1_quo[0]  = '0;
   assign d1_den[0]  = ONE_2F + s1_a2_ff;
   assign d1_side[0] = s1_side_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div1
      snm_div_cell #(.REM_W(64), .Q_W(32), .SIDE_W(FRONT_W)) u_cell (
         .clock (clock),
         .en    (en),
         .rem_i (d1_rem[i]),
         .quo_i (d1_quo[i]),
         .den_i (d1_den[i]),
         .side_i(d1_side[i]),
         .rem_o (d1_rem[i+1]),
         .quo_o (d1_quo[i+1]),
         .den_o (d1_den[i+1]),
         .side_o(d1_side[i+1])
      );
   end

   // Root chain: |delta| in Q0.30
   logic [SQRT_W-1:0]  r1_rad  [0:SQRT_STEPS];
   logic [SQRT_W-1:0]  r1_root [0:SQRT_STEPS];
   logic [FRONT_W-1:0] r1_side [0:SQRT_STEPS];

   assign r1_rad[0]  = SQRT_W'(d1_quo[DIV_STEPS]) << 28;
   assign r1_root[0] = '0;
   assign r1_side[0] = d1_side[DIV_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt1
      snm_sqrt_cell #(.W(SQRT_W), .BIT_POS(SQRT_W - 2 - 2 * i), .SIDE_W(FRONT_W)) u_cell (
         .clock (clock),
         .en    (en),
         .rad_i (r1_rad[i]),
         .root_i(r1_root[i]),
         .side_i(r1_side[i]),
         .rad_o (r1_rad[i+1]),
         .root_o(r1_root[i+1]),
         .side_o(r1_side[i+1])
      );
   end

   // Stage M1: m = delta * sqrt(2/pi)
   front_type   m1_side_ff;
   logic [29:0] m1_m_ff;
   logic [59:0] m1_prod;

   assign m1_prod = 60'(r1_root[SQRT_STEPS][29:0]) * 60'(K_SQRT_2_PI);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_side_ff <= front_type'(r1_side[SQRT_STEPS]);
         m1_m_ff    <= m1_prod[59:30];
      end
   end

   // Stage M2: m^2 and the mean offset scale*m
   front_type   m2_side_ff;
   logic [29:0] m2_m_ff, m2_m2_ff;
   logic [30:0] m2_term_ff;
   logic [59:0] m2_sq;
   logic [60:0] m2_tp;

   assign m2_sq = 60'(m1_m_ff) * 60'(m1_m_ff);
   assign m2_tp = 61'(m1_side_ff.sc) * 61'(m1_m_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m2_side_ff <= m1_side_ff;
         m2_m_ff    <= m1_m_ff;
         m2_m2_ff   <= m2_sq[59:30];
         m2_term_ff <= m2_tp[60:30];
      end
   end

   // Stage M3: y = 1 - m^2 and the saturated mean
   mid_type            m3_side_ff;
   logic signed [33:0] mean_sum;
   logic signed [31:0] mean_sat;

   always_comb begin
      if (m2_side_ff.neg) begin
         mean_sum = 34'(m2_side_ff.loc) - $signed({3'b000, m2_term_ff});
      end else begin
         mean_sum = 34'(m2_side_ff.loc) + $signed({3'b000, m2_term_ff});
      end
      if (mean_sum > 34'sh0_7FFF_FFFF) begin
         mean_sat = 32'sh7FFF_FFFF;
      end else if (mean_sum < -34'sh0_8000_0000) begin
         mean_sat = -32'sh8000_0000;
      end else begin
         mean_sat = mean_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_side_ff.mean <= mean_sat;
         m3_side_ff.m    <= m2_m_ff;
         m3_side_ff.m2   <= m2_m2_ff;
         m3_side_ff.y    <= Q30_ONE - 31'(m2_m2_ff);
         m3_side_ff.sc   <= m2_side_ff.sc;
         m3_side_ff.neg  <= m2_side_ff.neg;
      end
   end

   // Root chain: sqrt(y) in Q0.30
   logic [SQRT_W-1:0] r2_rad  [0:SQRT_STEPS];
   logic [SQRT_W-1:0] r2_root [0:SQRT_STEPS];
   logic [MID_W-1:0]  r2_side [0:SQRT_STEPS];

   assign r2_rad[0]  = SQRT_W'(m3_side_ff.y) << Q_SH;
   assign r2_root[0] = '0;
   assign r2_side[0] = m3_side_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt2
      snm_sqrt_cell #(.W(SQRT_W), .BIT_POS(SQRT_W - 2 - 2 * i), .SIDE_W(MID_W)) u_cell (
         .clock (clock),
         .en    (en),
         .rad_i (r2_rad[i]),
         .root_i(r2_root[i]),
         .side_i(r2_side[i]),
         .rad_o (r2_rad[i+1]),
         .root_o(r2_root[i+1]),
         .side_o(r2_side[i+1])
      );
   end

   // Stage P1: independent products of the moment terms
   mid_type     p1_in;
   logic [30:0] ysq;
   logic [61:0] sd_p, m3_p, y32_p, m4_p, y2_p;
   logic [31:0] sd_sh;

   assign p1_in = mid_type'(r2_side[SQRT_STEPS]);
   assign ysq   = r2_root[SQRT_STEPS][30:0];
   assign sd_p  = 62'(p1_in.sc) * 62'(ysq);
   assign m3_p  = 62'(p1_in.m2) * 62'(p1_in.m);
   assign y32_p = 62'(p1_in.y) * 62'(ysq);
   assign m4_p  = 62'(p1_in.m2) * 62'(p1_in.m2);
   assign y2_p  = 62'(p1_in.y) * 62'(p1_in.y);
   assign sd_sh = sd_p[61:30];

   logic signed [31:0] p1_mean_ff;
   logic               p1_neg_ff;
   logic [30:0]        p1_y_ff, p1_sd_ff, p1_y32_ff, p1_y2_ff;
   logic [29:0]        p1_m3_ff, p1_m4_ff;
   logic [61:0]        p1_ps_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_mean_ff <= p1_in.mean;
         p1_neg_ff  <= p1_in.neg;
         p1_y_ff    <= p1_in.y;
         p1_sd_ff   <= sd_sh[31] ? 31'h7FFF_FFFF : sd_sh[30:0];
         p1_m3_ff   <= m3_p[59:30];
         p1_y32_ff  <= y32_p[60:30];
         p1_m4_ff   <= m4_p[59:30];
         p1_y2_ff   <= y2_p[60:30];
         p1_ps_ff   <= 62'(p1_in.sc) * 62'(p1_in.sc);
      end
   end

   // Stage P2: split scale^2 * y into two partial products
   logic signed [31:0] p2_mean_ff;
   logic               p2_neg_ff;
   logic [30:0]        p2_sd_ff, p2_y32_ff, p2_y2_ff;
   logic [29:0]        p2_m3_ff, p2_m4_ff;
   logic [61:0]        p2_vh_ff, p2_vl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_mean_ff <= p1_mean_ff;
         p2_neg_ff  <= p1_neg_ff;
         p2_sd_ff   <= p1_sd_ff;
         p2_y32_ff  <= p1_y32_ff;
         p2_y2_ff   <= p1_y2_ff;
         p2_m3_ff   <= p1_m3_ff;
         p2_m4_ff   <= p1_m4_ff;
         p2_vh_ff   <= 62'(p1_ps_ff[61:31]) * 62'(p1_y_ff);
         p2_vl_ff   <= 62'(p1_ps_ff[30:0]) * 62'(p1_y_ff);
      end
   end

   // Stage P3: combine and saturate the variance
   logic [92:0] var_full, var_sh;
   back_type    p3_side_ff;
   logic        p3_neg_ff;
   logic [30:0] p3_y32_ff, p3_y2_ff;
   logic [29:0] p3_m3_ff, p3_m4_ff;

   assign var_full = (93'(p2_vh_ff) << 31) + 93'(p2_vl_ff);
   assign var_sh   = var_full >> VAR_SH;

   always_ff @(posedge clock) begin
      if (en) begin
         p3_side_ff.mean  <= p2_mean_ff;
         p3_side_ff.var_v <= (var_sh > VAR_MAX) ? VAR_MAX[45:0] : var_sh[45:0];
         p3_side_ff.sd    <= p2_sd_ff;
         p3_neg_ff        <= p2_neg_ff;
         p3_y32_ff        <= p2_y32_ff;
         p3_y2_ff         <= p2_y2_ff;
         p3_m3_ff         <= p2_m3_ff;
         p3_m4_ff         <= p2_m4_ff;
      end
   end

   // Divider chains: m^3 / y^1.5 and m^4 / y^2 in Q.30
   logic [31:0]       dk_rem  [0:DIV_STEPS];
   logic [31:0]       dk_quo  [0:DIV_STEPS];
   logic [31:0]       dk_den  [0:DIV_STEPS];
   logic [BACK_W-1:0] dk_side [0:DIV_STEPS];
   logic [31:0]       dq_rem  [0:DIV_STEPS];
   logic [31:0]       dq_quo  [0:DIV_STEPS];
   logic [31:0]       dq_den  [0:DIV_STEPS];
   logic              dq_side [0:DIV_STEPS];

   assign dk_rem[0]  = 32'(p3_m3_ff[29:2]);
   assign dk_quo[0]  = {p3_m3_ff[1:0], 30'd0};
   assign dk_den[0]  = 32'(p3_y32_ff);
   assign dk_side[0] = p3_side_ff;
   assign dq_rem[0]  = 32'(p3_m4_ff[29:2]);
   assign dq_quo[0]  = {p3_m4_ff[1:0], 30'd0};
   assign dq_den[0]  = 32'(p3_y2_ff);
   assign dq_side[0] = p3_neg_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div2
      snm_div_cell #(.REM_W(32), .Q_W(32), .SIDE_W(BACK_W)) u_skew (
         .clock (clock),
         .en    (en),
         .rem_i (dk_rem[i]),
         .quo_i (dk_quo[i]),
         .den_i (dk_den[i]),
         .side_i(dk_side[i]),
         .rem_o (dk_rem[i+1]),
         .quo_o (dk_quo[i+1]),
         .den_o (dk_den[i+1]),
         .side_o(dk_side[i+1])
      );
      snm_div_cell #(.REM_W(32), .Q_W(32), .SIDE_W(1)) u_kurt (
         .clock (clock),
         .en    (en),
         .rem_i (dq_rem[i]),
         .quo_i (dq_quo[i]),
         .den_i (dq_den[i]),
         .side_i(dq_side[i]),
         .rem_o (dq_rem[i+1]),
         .quo_o (dq_quo[i+1]),
         .den_o (dq_den[i+1]),
         .side_o(dq_side[i+1])
      );
   end

   // Output stage: scale by the moment constants, clamp, apply sign
   back_type    out_side;
   logic        out_neg;
   logic [61:0] sk_p, ku_p;
   logic [61:0] sk_sh, ku_sh;
   logic [16:0] sk_v, ku_v;

   assign out_side = back_type'(dk_side[DIV_STEPS]);
   assign out_neg  = dq_side[DIV_STEPS];
   assign sk_p     = 62'(dk_quo[DIV_STEPS]) * 62'(K_SKEW);
   assign ku_p     = 62'(dq_quo[DIV_STEPS]) * 62'(K_KURT);
   assign sk_sh    = sk_p >> MOM_SH;
   assign ku_sh    = ku_p >> MOM_SH;
   assign sk_v     = (64'(sk_sh) > MOM_LIM) ? MOM_LIM[16:0] : sk_sh[16:0];
   assign ku_v     = (64'(ku_sh) > MOM_LIM) ? MOM_LIM[16:0] : ku_sh[16:0];

   logic signed [31:0] rsp_mean_ff;
   logic [45:0]        rsp_var_ff;
   logic [30:0]        rsp_sd_ff;
   logic signed [17:0] rsp_skew_ff;
   logic [16:0]        rsp_kurt_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_mean_ff <= out_side.mean;
         rsp_var_ff  <= out_side.var_v;
         rsp_sd_ff   <= out_side.sd;
         rsp_skew_ff <= out_neg ? -$signed(18'(sk_v)) : $signed(18'(sk_v));
         rsp_kurt_ff <= ku_v;
      end
   end

   assign rsp_valid               = vld_ff[PIPE_LAT-1];
   assign rsp_mean_out            = rsp_mean_ff;
   assign rsp_variance_out        = rsp_var_ff;
   assign rsp_std_dev_out         = rsp_sd_ff;
   assign rsp_skewness_out        = rsp_skew_ff;
   assign rsp_excess_kurtosis_out = rsp_kurt_ff;

endmodule
